// ----- design/lcs_pkg.sv -----
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types, constants and helpers of the linear counting sketch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lcs_pkg;

  // default for the largest bitmap size (log2 of bits)
  localparam int MAX_PRECISION_D = 16;

  localparam int PREC_W    = 5;
  localparam int EST_W     = 20;
  localparam int CNT_OUT_W = 17;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int WORD_BITS = 64;

  localparam logic [PREC_W-1:0] PREC_MIN   = 5'd6;
  localparam logic [PREC_W-1:0] PREC_RESET = 5'd16;
  localparam logic [31:0]       LN2_Q32    = 32'd2977044472;
  localparam logic [EST_W-1:0]  EST_MAX    = '1;

  // register index decoded from paddr[2]
  localparam logic REG_PRECISION = 1'b0;

  // item function codes
  localparam logic FUNC_ADD      = 1'b0;
  localparam logic FUNC_ESTIMATE = 1'b1;

  // one queued item, apart from its word address
  typedef struct packed {
    logic       func;
    logic [5:0] bit_pos;
  } lcs_cmd_t;

  // limit a written precision to the supported range
  function automatic logic [PREC_W-1:0] clamp_prec(input logic [PREC_W-1:0] v,
                                                   input logic [PREC_W-1:0] maxp);
    logic [PREC_W-1:0] r;
    r = v;
    if (v < PREC_MIN) r = PREC_MIN;
    else if (v > maxp) r = maxp;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/linear_counting_sketch.sv -----
// ----------------------------------------------------------------------------
// linear_counting_sketch
// Linear counting cardinality estimator with an APB precision register.
// ----------------------------------------------------------------------------
// Add beats: queued, then read-modify-written in the back end (one RAM read
//   port) via its IDLE and RMW states; the next item waits for the write.
// Estimate beats: the result strobe follows the 32-step squaring loop and the
//   scaling steps of the log unit; a full bitmap skips the loop.
// Reset and every precision write start a clearing pass over all
//   2^(MAX_PRECISION-6) bitmap words (at least two) with busy high;
//   results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module linear_counting_sketch #(
  parameter int MAX_PRECISION = lcs_pkg::MAX_PRECISION_D
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_func,
  input  wire logic [63:0]                   in_hash_value,
  output logic                               out_strobe,
  output logic [lcs_pkg::EST_W-1:0]          out_estimate,
  output logic [lcs_pkg::CNT_OUT_W-1:0]      out_unset_count,
  output logic                               out_saturated,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lcs_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [lcs_pkg::DATA_W-1:0]    pwdata,
  output logic [lcs_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);
  import lcs_pkg::*;

  localparam int WORD_W = (MAX_PRECISION > 6) ? MAX_PRECISION - 6 : 1;
  localparam int DEPTH  = 1 << WORD_W;
  localparam logic [PREC_W-1:0] PREC_MAX = PREC_W'(MAX_PRECISION);

  logic [PREC_W-1:0] prec_r;
  logic              wr_prec;
  logic              pop, clearing, q_valid;
  lcs_cmd_t          q_cmd;
  logic [WORD_W-1:0] q_word;

  // register write on the access phase
  assign pready  = 1'b1;
  assign wr_prec = psel && penable && pwrite && (paddr[2] == REG_PRECISION);
  assign prdata  = (paddr[2] == REG_PRECISION) ? DATA_W'(prec_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) prec_r <= clamp_prec(PREC_RESET, PREC_MAX);
    else if (wr_prec) prec_r <= clamp_prec(pwdata[PREC_W-1:0], PREC_MAX);
  end

  lcs_front #(.MAX_PRECISION(MAX_PRECISION), .WORD_W(WORD_W)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_func       (in_func),
    .in_hash_value (in_hash_value),
    .prec          (prec_r),
    .clearing      (clearing),
    .pop           (pop),
    .busy          (busy),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_word        (q_word)
  );

  lcs_back #(.MAX_PRECISION(MAX_PRECISION), .WORD_W(WORD_W), .DEPTH(DEPTH)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .clear_req       (wr_prec),
    .prec            (prec_r),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_word          (q_word),
    .pop             (pop),
    .clearing        (clearing),
    .out_strobe      (out_strobe),
    .out_estimate    (out_estimate),
    .out_unset_count (out_unset_count),
    .out_saturated   (out_saturated)
  );

endmodule

`default_nettype wire

// ----- design/lcs_ram.sv -----
// ----------------------------------------------------------------------------
// lcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/lcs_front.sv -----
// ----------------------------------------------------------------------------
// lcs_front
// Accepts items, extracts the bucket word and bit, and queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcs_front #(
  parameter int MAX_PRECISION = lcs_pkg::MAX_PRECISION_D,
  parameter int WORD_W        = 10
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic                      in_func,
  input  wire logic [63:0]               in_hash_value,
  input  wire logic [lcs_pkg::PREC_W-1:0] prec,
  input  wire logic                      clearing,
  input  wire logic                      pop,
  output logic                           busy,
  output logic                           q_valid,
  output lcs_pkg::lcs_cmd_t              q_cmd,
  output logic [WORD_W-1:0]              q_word
);
  import lcs_pkg::*;

  localparam int QD = 4;

  lcs_cmd_t          cmd_r  [QD];
  logic [WORD_W-1:0] word_r [QD];
  logic [1:0]        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic              push;
  logic [63:0]       shifted;
  logic [MAX_PRECISION-1:0] idx;
  logic [MAX_PRECISION-1:0] word_full;

  // top precision bits of the hash select the bucket
  always_comb begin
    shifted   = in_hash_value >> (7'd64 - 7'(prec));
    idx       = shifted[MAX_PRECISION-1:0];
    word_full = idx >> 6;
  end

  assign busy    = clearing || (cnt_r == 3'(QD));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 3'd0);
  assign q_cmd   = cmd_r[rp_r];
  assign q_word  = word_r[rp_r];

  // advance queue pointers
  always_comb begin
    wp_nxt  = push ? wp_r + 2'd1 : wp_r;
    rp_nxt  = pop ? rp_r + 2'd1 : rp_r;
    cnt_nxt = cnt_r + 3'(push) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // store the accepted beat
  always_ff @(posedge clk) begin
    if (push) begin
      cmd_r[wp_r].func    <= in_func;
      cmd_r[wp_r].bit_pos <= idx[5:0];
      word_r[wp_r]        <= word_full[WORD_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- design/lcs_log.sv -----
// ----------------------------------------------------------------------------
// lcs_log
// Iterative fixed-point log unit: one squaring step per cycle, then scaling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcs_log #(
  parameter int MAX_PRECISION = lcs_pkg::MAX_PRECISION_D
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       go,
  input  wire logic [MAX_PRECISION:0]     s,
  input  wire logic [lcs_pkg::PREC_W-1:0] prec,
  output logic                            done,
  output logic [lcs_pkg::EST_W-1:0]       est,
  output logic                            sat
);
  import lcs_pkg::*;

  localparam int CNT_W = MAX_PRECISION + 1;

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_ITER = 3'd1;
  localparam logic [2:0] P_MUL  = 3'd2;
  localparam logic [2:0] P_FIN  = 3'd3;

  logic [2:0]  ph_r;
  logic [4:0]  it_r;
  logic [31:0] y_r, frac_r;
  logic [4:0]  k_r;
  logic [36:0] pint_r;
  logic [31:0] pfr_r;
  logic        done_r, sat_r;
  logic [EST_W-1:0] est_r;

  logic [4:0]  k;
  logic [63:0] sq;
  logic [32:0] t;
  logic [36:0] lv;
  logic [63:0] pfr_full;
  logic [37:0] ln;
  logic [37:0] est_full;

  // leading one of the count
  always_comb begin
    k = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (s[i]) k = 5'(i);
    end
  end

  always_comb begin
    sq       = 64'(y_r) * 64'(y_r);
    t        = sq[63:31];
    lv       = {prec, 32'd0} - {k_r, frac_r};
    pfr_full = 64'(lv[31:0]) * 64'(LN2_Q32);
    ln       = 38'(pint_r) + 38'(pfr_r);
    est_full = ln >> (6'd32 - 6'(prec));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= P_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (ph_r)
        P_IDLE: begin
          if (go) begin
            if (s == '0) begin
              est_r  <= EST_MAX;
              sat_r  <= 1'b1;
              done_r <= 1'b1;
            end else begin
              k_r  <= k;
              y_r  <= 32'(s) << (5'd31 - k);
              it_r <= '0;
              ph_r <= P_ITER;
            end
          end
        end
        // square and take one fraction bit
        P_ITER: begin
          frac_r <= {frac_r[30:0], t[32]};
          y_r    <= t[32] ? t[32:1] : t[31:0];
          it_r   <= it_r + 5'd1;
          if (it_r == 5'd31) ph_r <= P_MUL;
        end
        // scale log2 to natural log
        P_MUL: begin
          pint_r <= 37'(lv[36:32]) * 37'(LN2_Q32);
          pfr_r  <= pfr_full[63:32];
          ph_r   <= P_FIN;
        end
        P_FIN: begin
          if (est_full > 38'(EST_MAX)) begin
            est_r <= EST_MAX;
            sat_r <= 1'b1;
          end else begin
            est_r <= est_full[EST_W-1:0];
            sat_r <= 1'b0;
          end
          done_r <= 1'b1;
          ph_r   <= P_IDLE;
        end
        default: ph_r <= P_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign est  = est_r;
  assign sat  = sat_r;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("result strobe longer than one cycle");
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && sat_r) |-> (est_r == EST_MAX)) else $error("saturated estimate not all ones");
  a_iter_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == P_ITER) |-> !done_r) else $error("result during iteration");

endmodule

`default_nettype wire

// ----- design/lcs_back.sv -----
// ----------------------------------------------------------------------------
// lcs_back
// Owns the bitmap: clearing sweep, read-modify-write of adds, estimates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcs_back #(
  parameter int MAX_PRECISION = lcs_pkg::MAX_PRECISION_D,
  parameter int WORD_W        = 10,
  parameter int DEPTH         = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       clear_req,
  input  wire logic [lcs_pkg::PREC_W-1:0] prec,
  input  wire logic                       q_valid,
  input  wire lcs_pkg::lcs_cmd_t          q_cmd,
  input  wire logic [WORD_W-1:0]          q_word,
  output logic                            pop,
  output logic                            clearing,
  output logic                            out_strobe,
  output logic [lcs_pkg::EST_W-1:0]       out_estimate,
  output logic [lcs_pkg::CNT_OUT_W-1:0]   out_unset_count,
  output logic                            out_saturated
);
  import lcs_pkg::*;

  localparam int CNT_W = MAX_PRECISION + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RMW  = 3'd1;
  localparam logic [2:0] ST_LOG  = 3'd2;
  localparam logic [2:0] ST_CLR  = 3'd3;

  logic [2:0]        st_r;
  logic [WORD_W-1:0] clr_r, word_r;
  logic [5:0]        bit_r;
  logic [CNT_W-1:0]  zero_r, m_full;
  logic              we;
  logic [WORD_W-1:0] waddr;
  logic [63:0]       wdata, rdata;
  logic              log_go, log_done;

  assign m_full   = CNT_W'(1) << prec;
  assign clearing = (st_r == ST_CLR);
  assign pop      = (st_r == ST_IDLE) && q_valid;
  assign log_go   = pop && (q_cmd.func == FUNC_ESTIMATE);

  // write port: clearing sweep or bit set
  always_comb begin
    we    = 1'b0;
    waddr = word_r;
    wdata = rdata | (64'd1 << bit_r);
    if (st_r == ST_CLR) begin
      we    = 1'b1;
      waddr = clr_r;
      wdata = '0;
    end else if (st_r == ST_RMW) begin
      we = !rdata[bit_r];
    end
  end

  lcs_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr[$clog2(DEPTH)-1:0]),
    .wdata (wdata),
    .raddr (q_word[$clog2(DEPTH)-1:0]),
    .rdata (rdata)
  );

  lcs_log #(.MAX_PRECISION(MAX_PRECISION)) u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (log_go),
    .s     (zero_r),
    .prec  (prec),
    .done  (log_done),
    .est   (out_estimate),
    .sat   (out_saturated)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_CLR;
      clr_r  <= '0;
      zero_r <= m_full;
    end else if (clear_req) begin
      st_r  <= ST_CLR;
      clr_r <= '0;
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (pop) begin
            word_r <= q_word;
            bit_r  <= q_cmd.bit_pos;
            st_r   <= (q_cmd.func == FUNC_ADD) ? ST_RMW : ST_LOG;
          end
        end
        // drop a repeated bucket, else count it
        ST_RMW: begin
          if (!rdata[bit_r] && zero_r != '0) zero_r <= zero_r - CNT_W'(1);
          st_r <= ST_IDLE;
        end
        ST_LOG: begin
          if (log_done) st_r <= ST_IDLE;
        end
        ST_CLR: begin
          clr_r <= clr_r + WORD_W'(1);
          if (clr_r == WORD_W'(DEPTH - 1)) begin
            zero_r <= m_full;
            st_r   <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_strobe      = log_done;
  assign out_unset_count = CNT_OUT_W'(zero_r);

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !clearing) else $error("item taken during clear");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RMW) |-> (zero_r <= m_full)) else $error("unset count above bitmap size");
  a_strobe_log: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(st_r == ST_LOG || (st_r == ST_IDLE && q_valid)))
    else $error("result without estimate request");

endmodule

`default_nettype wire
